/* rtl/fasta_record_classifier_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef FASTA_RECORD_CLASSIFIER_UNIT_MACROS_SVH
`define FASTA_RECORD_CLASSIFIER_UNIT_MACROS_SVH

// Checked outside reset.
`define FRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/frc_pkg.sv */
`default_nettype none

package frc_pkg;

  localparam int LENGTH_BITS  = 24;
  localparam int OUT_LEN_BITS = 24;
  localparam int TYPE_BITS    = 3;
  localparam int OUT_FIELD_BITS = TYPE_BITS + 2 * OUT_LEN_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

  localparam logic [LENGTH_BITS-1:0]  LEN_MAX     = '1;
  localparam logic [LENGTH_BITS-1:0]  LEN_ONE     = LENGTH_BITS'(1);
  localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = '1;

  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_T    = 8'h54;

  localparam logic STATUS_SUMMARY = 1'b0;
  localparam logic STATUS_ERROR   = 1'b1;

  localparam logic [TYPE_BITS-1:0] ST_UNKNOWN      = 3'd0;
  localparam logic [TYPE_BITS-1:0] ST_DNA          = 3'd1;
  localparam logic [TYPE_BITS-1:0] ST_RNA          = 3'd2;
  localparam logic [TYPE_BITS-1:0] ST_PROTEIN      = 3'd3;
  localparam logic [TYPE_BITS-1:0] ST_EXT_DNA     = 3'd4;
  localparam logic [TYPE_BITS-1:0] ST_EXT_RNA     = 3'd5;
  localparam logic [TYPE_BITS-1:0] ST_EXT_PROTEIN = 3'd6;

  typedef enum logic [3:0] {
    LK_NONE    = 4'b0001,
    LK_HEADER  = 4'b0010,
    LK_COMMENT = 4'b0100,
    LK_SEQ     = 4'b1000
  } line_kind_t;

  typedef struct packed {
    logic                   all_protein;
    logic                   all_nucleic;
    logic                   saw_uracil;
    logic                   saw_thymine;
    logic                   saw_nonbasic;
    logic [1:0]             ext_count;
    logic                   last_star;
    logic [LENGTH_BITS-1:0] char_count;
    logic [LENGTH_BITS-1:0] dash_count;
  } rec_t;

  localparam rec_t REC_CLEAR = '{
    all_protein:  1'b1,
    all_nucleic:  1'b1,
    saw_uracil:   1'b0,
    saw_thymine:  1'b0,
    saw_nonbasic: 1'b0,
    ext_count:    2'd0,
    last_star:    1'b0,
    char_count:   '0,
    dash_count:   '0
  };

  typedef struct packed {
    logic                    status;
    logic [TYPE_BITS-1:0]    seq_type;
    logic [OUT_LEN_BITS-1:0] gapped_length;
    logic [OUT_LEN_BITS-1:0] ungapped_length;
  } result_t;

  localparam result_t ERROR_RESULT = '{
    status:          STATUS_ERROR,
    seq_type:        ST_UNKNOWN,
    gapped_length:   '0,
    ungapped_length: '0
  };

  typedef struct packed {
    logic    emit;
    result_t result;
  } step_t;

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    if (b >= "a" && b <= "z") begin
      return b - 8'd32;
    end
    return b;
  endfunction

  function automatic logic is_dropped(input logic [7:0] b);
    return (b == " ") || (b >= 8'd9 && b <= 8'd13) || (b >= "0" && b <= "9");
  endfunction

  function automatic logic is_protein(input logic [7:0] c);
    case (c)
      "A", "B", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M", "N",
      "P", "Q", "R", "S", "T", "U", "V", "W", "Y", "Z", "X", "*", "-": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_nucleic(input logic [7:0] c);
    case (c)
      "A", "C", "G", "T", "U", "R", "Y", "K", "M", "S", "W", "B", "H", "V", "N",
      "-": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_basic(input logic [7:0] c);
    case (c)
      "A", "C", "G", "T", "U", "-": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_ext_protein(input logic [7:0] c);
    case (c)
      "B", "U", "Z", "X", "*": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic rec_t take_char(input rec_t r, input logic [7:0] c);
    rec_t n;
    n = r;
    if (!is_protein(c)) n.all_protein = 1'b0;
    if (!is_nucleic(c)) n.all_nucleic = 1'b0;
    if (c == CH_U) n.saw_uracil = 1'b1;
    if (c == CH_T) n.saw_thymine = 1'b1;
    if (!is_basic(c)) n.saw_nonbasic = 1'b1;
    if (is_ext_protein(c) && r.ext_count != 2'd2) n.ext_count = r.ext_count + 2'd1;
    n.last_star = (c == CH_STAR);
    if (c == CH_DASH) begin
      if (r.dash_count != LEN_MAX) n.dash_count = r.dash_count + LEN_ONE;
    end else begin
      if (r.char_count != LEN_MAX) n.char_count = r.char_count + LEN_ONE;
    end
    return n;
  endfunction

  function automatic logic [OUT_LEN_BITS-1:0] clamp_out(input logic [LENGTH_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > 33'(OUT_LEN_MAX)) begin
      return OUT_LEN_MAX;
    end
    return w[OUT_LEN_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/frc_classify.sv */
`default_nettype none

module frc_classify (
  input  wire frc_pkg::rec_t    rec,
  output frc_pkg::result_t      summary
);

  logic [frc_pkg::LENGTH_BITS:0]   gap_sum;
  logic [frc_pkg::LENGTH_BITS-1:0] gapped;
  logic [frc_pkg::LENGTH_BITS-1:0] ungapped;
  logic [frc_pkg::TYPE_BITS-1:0]   seq_type;
  logic                            d;
  logic                            r;
  logic                            x;
  logic                            p;

  assign d = rec.saw_thymine;
  assign r = rec.saw_uracil;
  assign x = rec.saw_nonbasic;
  assign p = rec.all_protein;

  always_comb begin
    seq_type = frc_pkg::ST_UNKNOWN;
    if (p) begin
      if (rec.ext_count == 2'd0 || (rec.ext_count == 2'd1 && rec.last_star)) begin
        seq_type = frc_pkg::ST_PROTEIN;
      end else begin
        seq_type = frc_pkg::ST_EXT_PROTEIN;
      end
    end
    if (rec.all_nucleic) begin
      if (p && d && r) begin
        seq_type = seq_type;
      end else if (p && x) begin
        seq_type = frc_pkg::ST_UNKNOWN;
      end else if (d && !r && !x) begin
        seq_type = frc_pkg::ST_DNA;
      end else if (r && !d && !x) begin
        seq_type = frc_pkg::ST_RNA;
      end else if (d && x && !r) begin
        seq_type = frc_pkg::ST_EXT_DNA;
      end else if (r && x && !d) begin
        seq_type = frc_pkg::ST_EXT_RNA;
      end else begin
        seq_type = frc_pkg::ST_UNKNOWN;
      end
    end
  end

  assign gap_sum = {1'b0, rec.char_count} + {1'b0, rec.dash_count};
  assign gapped  = gap_sum[frc_pkg::LENGTH_BITS] ? frc_pkg::LEN_MAX
                                                 : gap_sum[frc_pkg::LENGTH_BITS-1:0];

  always_comb begin
    ungapped = rec.char_count;
    if (rec.last_star && rec.char_count != '0 && rec.char_count != frc_pkg::LEN_MAX) begin
      ungapped = rec.char_count - frc_pkg::LEN_ONE;
    end
  end

  assign summary.status          = frc_pkg::STATUS_SUMMARY;
  assign summary.seq_type        = seq_type;
  assign summary.gapped_length   = frc_pkg::clamp_out(gapped);
  assign summary.ungapped_length = frc_pkg::clamp_out(ungapped);

endmodule

`default_nettype wire

/* rtl/frc_parser.sv */
`default_nettype none

module frc_parser (
  input  wire                clk,
  input  wire                rst,
  input  wire                step,
  input  wire  [7:0]         data_byte,
  input  wire                end_of_input,
  output frc_pkg::step_t     step_out
);

  logic                  at_line_start;
  logic                  at_line_start_next;
  frc_pkg::line_kind_t   line_kind;
  frc_pkg::line_kind_t   line_kind_next;
  logic                  record_open;
  logic                  record_open_next;
  logic                  error_hold;
  logic                  error_hold_next;
  frc_pkg::rec_t         rec;
  frc_pkg::rec_t         rec_next;
  frc_pkg::result_t      summary;
  logic [7:0]            upper;
  logic                  take;
  logic                  bad_start;

  frc_classify u_classify (
    .rec     (rec),
    .summary (summary)
  );

  assign upper     = frc_pkg::to_upper(data_byte);
  assign bad_start = data_byte != frc_pkg::CH_GT && data_byte != frc_pkg::CH_SEMI
                     && !record_open;

  always_comb begin
    at_line_start_next = at_line_start;
    line_kind_next     = line_kind;
    record_open_next   = record_open;
    error_hold_next    = error_hold;
    rec_next           = rec;
    step_out.emit      = 1'b0;
    step_out.result    = summary;
    take               = 1'b0;
    if (step) begin
      if (end_of_input) begin
        step_out.emit      = record_open && !error_hold;
        at_line_start_next = 1'b1;
        line_kind_next     = frc_pkg::LK_NONE;
        record_open_next   = 1'b0;
        error_hold_next    = 1'b0;
        rec_next           = frc_pkg::REC_CLEAR;
      end else if (!error_hold) begin
        if (at_line_start) begin
          at_line_start_next = 1'b0;
          if (data_byte == frc_pkg::CH_GT) begin
            step_out.emit    = record_open;
            rec_next         = frc_pkg::REC_CLEAR;
            record_open_next = 1'b1;
            line_kind_next   = frc_pkg::LK_HEADER;
          end else if (data_byte == frc_pkg::CH_SEMI) begin
            line_kind_next = frc_pkg::LK_COMMENT;
          end else if (bad_start) begin
            error_hold_next = 1'b1;
            step_out.emit   = 1'b1;
            step_out.result = frc_pkg::ERROR_RESULT;
          end else begin
            line_kind_next = frc_pkg::LK_SEQ;
          end
          if (!bad_start) begin
            if (data_byte == frc_pkg::CH_LF) begin
              at_line_start_next = 1'b1;
              line_kind_next     = frc_pkg::LK_NONE;
            end else if (line_kind_next == frc_pkg::LK_SEQ) begin
              take = 1'b1;
            end
          end
        end else if (data_byte == frc_pkg::CH_LF) begin
          at_line_start_next = 1'b1;
          line_kind_next     = frc_pkg::LK_NONE;
        end else if (line_kind == frc_pkg::LK_SEQ) begin
          take = 1'b1;
        end
      end
    end
    if (take) begin
      if (data_byte == frc_pkg::CH_NUL) begin
        line_kind_next = frc_pkg::LK_COMMENT;
      end else if (!frc_pkg::is_dropped(data_byte)) begin
        rec_next = frc_pkg::take_char(rec_next, upper);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      line_kind     <= frc_pkg::LK_NONE;
      record_open   <= 1'b0;
      error_hold    <= 1'b0;
      rec           <= frc_pkg::REC_CLEAR;
    end else begin
      at_line_start <= at_line_start_next;
      line_kind     <= line_kind_next;
      record_open   <= record_open_next;
      error_hold    <= error_hold_next;
      rec           <= rec_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/fasta_record_classifier_unit.sv */
// Channel   Dir  tdata (low bit up)                           tuser    tlast
// s_axis    in   data_byte[7:0]                               -        end_of_input
// m_axis    out  seq_type[2:0], gapped_length[26:3],          status   -
//                ungapped_length[50:27], zero pad[55:51]
//
// One byte a cycle while the result is not stalled: an input register, then one pass of
// flag and counter logic into the result register.
// Synchronous active-high reset returns to line start with no record open.
// A stalled result blocks only the input register; one more request is still taken while it is empty.
`default_nettype none

module fasta_record_classifier_unit (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [7:0]                         s_axis_tdata,  // data_byte
  input  wire                                s_axis_tlast,  // end_of_input
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [frc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // seq_type, gapped, ungapped
  output logic                               m_axis_tuser   // status
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_end;
  logic             advance;
  logic             step;
  frc_pkg::step_t   step_out;
  frc_pkg::result_t m_result;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = s1_valid && advance;
  assign s_axis_tready = !s1_valid || advance;

  frc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (s1_byte),
    .end_of_input (s1_end),
    .step_out     (step_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_end  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= step && step_out.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_result <= step_out.result;
    end
  end

  assign m_axis_tdata = {{frc_pkg::OUT_PAD_BITS{1'b0}}, m_result.ungapped_length,
                         m_result.gapped_length, m_result.seq_type};
  assign m_axis_tuser = m_result.status;

endmodule

`default_nettype wire

/* rtl/frc_checker.sv */
`default_nettype none
`include "fasta_record_classifier_unit_macros.svh"

module frc_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [frc_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input wire                               m_axis_tuser
);

  localparam int GapLo = frc_pkg::TYPE_BITS;
  localparam int UngLo = frc_pkg::TYPE_BITS + frc_pkg::OUT_LEN_BITS;

  `FRC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
  `FRC_ASSERT(a_error_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "parse error carries non-zero fields")
  `FRC_ASSERT(a_len_order, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[GapLo +: frc_pkg::OUT_LEN_BITS] >= m_axis_tdata[UngLo +: frc_pkg::OUT_LEN_BITS], "ungapped length exceeds gapped length")
  `FRC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid && s_axis_tready, "block not idle after reset")

endmodule

bind fasta_record_classifier_unit frc_checker u_frc_checker (.*);

`default_nettype wire
